FILE: hdl/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg
// Shared constants and the restoring-division step for the RGB to HSV block.
// ----------------------------------------------------------------------------
package rth_pkg;

   localparam int PIX_W = 8;
   localparam int NUM_W = 2 * PIX_W;
   localparam int HUE_SUM_W = 11;

   // Quotient bits resolved per pipeline stage of the divider.
   localparam int DIV_STEPS = 2;
   localparam int DIV_STAGES = PIX_W / DIV_STEPS;

   // Prep stage, divider stages, hue sum stage and output stage.
   localparam int TOTAL_STAGES = DIV_STAGES + 3;

   localparam logic [HUE_SUM_W-1:0] HUE_UNIT_YLW = 11'd256;
   localparam logic [HUE_SUM_W-1:0] HUE_UNIT_CYN = 11'd768;
   localparam logic [HUE_SUM_W-1:0] HUE_UNIT_MAG = 11'd1280;

   // x / 6 equals (x * 43691) >> 18 for every x below 2^16.
   localparam logic [15:0] RECIP_SIX = 16'd43691;
   localparam int RECIP_SHIFT = 18;
   localparam int PROD_W = HUE_SUM_W + 16;

   // Multiply an 8-bit value by 255 as a shift and a subtract.
   function automatic logic [NUM_W-1:0] times_full_scale(input logic [PIX_W-1:0] x);
      return {x, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, x};
   endfunction

   // One restoring-division step. Result holds the new remainder in the
   // upper bits and the quotient bit in bit zero. The remainder coming in
   // is always below the divisor.
   function automatic logic [PIX_W:0] div_step(input logic [PIX_W-1:0] rem,
                                                input logic nbit,
                                                input logic [PIX_W-1:0] den);
      logic [PIX_W:0] trial;
      logic [PIX_W:0] diff;
      trial = {rem, nbit};
      diff = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         return {diff[PIX_W-1:0], 1'b1};
      end else begin
         return {trial[PIX_W-1:0], 1'b0};
      end
   endfunction

endpackage

FILE: hdl/rgb_to_hsv_convert.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert
// Converts 8-bit RGB pixels to 8-bit hue, saturation and value.
// ----------------------------------------------------------------------------
// A request passes through the prep stage, the divider stages, the hue sum
// stage and the output stage. Throughput: one pixel per clock while the result
// channel is ready; the two pipelined dividers (two quotient bits per stage) set
// the depth of the pipeline. Each stage holds only while its successor is full and
// stalled, so bubbles close up. Reset clears every stage valid bit; payload is not reset.
module rgb_to_hsv_convert
   import rth_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // hue [7:0], saturation [15:8], value [23:16]
);

   localparam int LAST_ST = TOTAL_STAGES - 1;

   // Valid bits and advance enables for all stages. Stage zero is the
   // prep stage, then the divider stages, the hue sum and the output.
   logic [TOTAL_STAGES-1:0] valid_ff;
   logic [TOTAL_STAGES-1:0] valid_in;
   logic [TOTAL_STAGES-1:0] stage_en;

   always_comb begin
      stage_en[LAST_ST] = !valid_ff[LAST_ST] || rsp_tready;
      for (int s = LAST_ST - 1; s >= 0; s--) begin
         stage_en[s] = !valid_ff[s] || stage_en[s+1];
      end
   end

   assign valid_in = (stage_en & {valid_ff[LAST_ST-1:0], req_tvalid})
                   | (~stage_en & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[LAST_ST];

   // ---------------------------------------------------------------------
   // Prep stage: extremes, range, sextant choice and the two dividends.
   // ---------------------------------------------------------------------
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;

   assign red   = req_tdata[7:0];
   assign green = req_tdata[15:8];
   assign blue  = req_tdata[23:16];

   logic [PIX_W-1:0]     mx;
   logic [PIX_W-1:0]     mn;
   logic [PIX_W-1:0]     span;
   logic [PIX_W-1:0]     hue_c;
   logic [HUE_SUM_W-1:0] base_sel;
   logic                 add_sel;

   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) begin
         mx = green;
      end
      if (blue > mx) begin
         mx = blue;
      end
      if (green < mn) begin
         mn = green;
      end
      if (blue < mn) begin
         mn = blue;
      end
      span = mx - mn;

      // Ties for the largest favor red, then green. Within each branch the
      // smallest component decides which side of the primary hue we are on.
      if (mx == red) begin
         if (mn == green) begin
            hue_c = blue;
            base_sel = HUE_UNIT_MAG;
            add_sel = 1'b1;
         end else begin
            hue_c = green;
            base_sel = HUE_UNIT_YLW;
            add_sel = 1'b0;
         end
      end else if (mx == green) begin
         if (mn == blue) begin
            hue_c = red;
            base_sel = HUE_UNIT_YLW;
            add_sel = 1'b1;
         end else begin
            hue_c = blue;
            base_sel = HUE_UNIT_CYN;
            add_sel = 1'b0;
         end
      end else if (mn == red) begin
         hue_c = green;
         base_sel = HUE_UNIT_CYN;
         add_sel = 1'b1;
      end else begin
         hue_c = red;
         base_sel = HUE_UNIT_MAG;
         add_sel = 1'b0;
      end
   end

   logic [NUM_W-1:0]     sat_num_ff;
   logic [NUM_W-1:0]     hue_num_ff;
   logic [PIX_W-1:0]     span_ff;
   logic [PIX_W-1:0]     max_ff;
   logic                 chroma_ff;
   logic [HUE_SUM_W-1:0] base_ff;
   logic                 add_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sat_num_ff <= times_full_scale(span);
         hue_num_ff <= times_full_scale(mx - hue_c);
         span_ff    <= span;
         max_ff     <= mx;
         chroma_ff  <= (span != '0);
         base_ff    <= base_sel;
         add_ff     <= add_sel;
      end
   end

   // ---------------------------------------------------------------------
   // Divider stages. Saturation divides by the maximum and hue by the
   // range; when the range is zero both results are forced to zero later,
   // so a zero divisor never reaches the output.
   // ---------------------------------------------------------------------
   logic [PIX_W-1:0] sat_quo;
   logic [PIX_W-1:0] hue_quo;

   rth_divide u_sat_div (
      .clock    (clock),
      .stage_en (stage_en[DIV_STAGES:1]),
      .num_in   (sat_num_ff),
      .den_in   (max_ff),
      .quo      (sat_quo)
   );

   rth_divide u_hue_div (
      .clock    (clock),
      .stage_en (stage_en[DIV_STAGES:1]),
      .num_in   (hue_num_ff),
      .den_in   (span_ff),
      .quo      (hue_quo)
   );

   // Side payload travels next to the dividers.
   logic [PIX_W-1:0]     dmax_ff    [DIV_STAGES];
   logic                 dchroma_ff [DIV_STAGES];
   logic [HUE_SUM_W-1:0] dbase_ff   [DIV_STAGES];
   logic                 dadd_ff    [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_side
      if (s == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (stage_en[1]) begin
               dmax_ff[0]    <= max_ff;
               dchroma_ff[0] <= chroma_ff;
               dbase_ff[0]   <= base_ff;
               dadd_ff[0]    <= add_ff;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (stage_en[s+1]) begin
               dmax_ff[s]    <= dmax_ff[s-1];
               dchroma_ff[s] <= dchroma_ff[s-1];
               dbase_ff[s]   <= dbase_ff[s-1];
               dadd_ff[s]    <= dadd_ff[s-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Hue sum stage: offset the per-channel term from the sextant base.
   // ---------------------------------------------------------------------
   localparam int SUM_ST = DIV_STAGES + 1;

   logic [HUE_SUM_W-1:0] hsum_in;
   logic [HUE_SUM_W-1:0] hsum_ff;
   logic [PIX_W-1:0]     ssat_ff;
   logic [PIX_W-1:0]     smax_ff;
   logic                 schroma_ff;

   always_comb begin
      if (dadd_ff[DIV_STAGES-1]) begin
         hsum_in = dbase_ff[DIV_STAGES-1] + {{(HUE_SUM_W-PIX_W){1'b0}}, hue_quo};
      end else begin
         hsum_in = dbase_ff[DIV_STAGES-1] - {{(HUE_SUM_W-PIX_W){1'b0}}, hue_quo};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[SUM_ST]) begin
         hsum_ff    <= hsum_in;
         ssat_ff    <= sat_quo;
         smax_ff    <= dmax_ff[DIV_STAGES-1];
         schroma_ff <= dchroma_ff[DIV_STAGES-1];
      end
   end

   // ---------------------------------------------------------------------
   // Output stage: divide the hue sum by six through a reciprocal multiply.
   // Grey and black pixels give zero hue and zero saturation.
   // ---------------------------------------------------------------------
   logic [PROD_W-1:0] hprod;
   logic [PIX_W-1:0]  hue_in;
   logic [PIX_W-1:0]  sat_in;
   logic [PIX_W-1:0]  hue_ff;
   logic [PIX_W-1:0]  sat_ff;
   logic [PIX_W-1:0]  val_ff;

   assign hprod  = {{(PROD_W-HUE_SUM_W){1'b0}}, hsum_ff} * {{(PROD_W-16){1'b0}}, RECIP_SIX};
   assign hue_in = schroma_ff ? hprod[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT] : '0;
   assign sat_in = schroma_ff ? ssat_ff : '0;

   always_ff @(posedge clock) begin
      if (stage_en[LAST_ST]) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         val_ff <= smax_ff;
      end
   end

   assign rsp_tdata = {val_ff, sat_ff, hue_ff};

endmodule

FILE: hdl/rth_divide.sv
// ----------------------------------------------------------------------------
// rth_divide
// Pipelined restoring divider, 16-bit dividend over 8-bit divisor, for
// quotients known to fit in 8 bits.
// ----------------------------------------------------------------------------
module rth_divide
   import rth_pkg::*;
(
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] stage_en,
   input  logic [NUM_W-1:0]      num_in,
   input  logic [PIX_W-1:0]      den_in,
   output logic [PIX_W-1:0]      quo
);

   logic [PIX_W-1:0] rem_ff [DIV_STAGES];
   logic [PIX_W-1:0] low_ff [DIV_STAGES];
   logic [PIX_W-1:0] den_ff [DIV_STAGES];
   logic [PIX_W-1:0] quo_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [PIX_W-1:0] src_rem;
      logic [PIX_W-1:0] src_low;
      logic [PIX_W-1:0] src_den;
      logic [PIX_W-1:0] src_quo;
      logic [PIX_W-1:0] rem_in;
      logic [PIX_W-1:0] low_in;
      logic [PIX_W-1:0] quo_in;

      if (s == 0) begin : g_first
         // The upper dividend half is already below the divisor.
         assign src_rem = num_in[NUM_W-1:PIX_W];
         assign src_low = num_in[PIX_W-1:0];
         assign src_den = den_in;
         assign src_quo = '0;
      end else begin : g_next
         assign src_rem = rem_ff[s-1];
         assign src_low = low_ff[s-1];
         assign src_den = den_ff[s-1];
         assign src_quo = quo_ff[s-1];
      end

      always_comb begin
         logic [PIX_W:0] step;
         rem_in = src_rem;
         low_in = src_low;
         quo_in = src_quo;
         for (int k = 0; k < DIV_STEPS; k++) begin
            step = div_step(rem_in, low_in[PIX_W-1], src_den);
            rem_in = step[PIX_W:1];
            quo_in = {quo_in[PIX_W-2:0], step[0]};
            low_in = {low_in[PIX_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            rem_ff[s] <= rem_in;
            low_ff[s] <= low_in;
            den_ff[s] <= src_den;
            quo_ff[s] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule

FILE: hdl/rth_checker.sv
// ----------------------------------------------------------------------------
// rth_checker
// Port-level checks for the RGB to HSV block, bound to the top level.
// ----------------------------------------------------------------------------
module rth_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // A held result keeps its data until it is taken.
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result changed while stalled");

   // The pipeline is empty right after reset.
   property p_reset_empty;
      @(posedge clock) reset |=> !rsp_tvalid;
   endproperty
   a_reset_empty: assert property (p_reset_empty) else $error("result valid after reset");

   // Requests are refused only when a result is stalled at the output.
   property p_backpressure_only;
      @(posedge clock) disable iff (reset)
         !req_tready |-> rsp_tvalid && !rsp_tready;
   endproperty
   a_backpressure_only: assert property (p_backpressure_only)
      else $error("request refused without output stall");

   // A colorless result carries zero hue, and nonzero saturation needs value.
   property p_grey_hue;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && (rsp_tdata[15:8] == 8'd0) |-> rsp_tdata[7:0] == 8'd0;
   endproperty
   a_grey_hue: assert property (p_grey_hue) else $error("hue nonzero with zero saturation");

   property p_sat_needs_value;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && (rsp_tdata[15:8] != 8'd0) |-> rsp_tdata[23:16] != 8'd0;
   endproperty
   a_sat_needs_value: assert property (p_sat_needs_value)
      else $error("saturation nonzero with zero value");

endmodule

bind rgb_to_hsv_convert rth_checker u_rth_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB to HSV converter: pixels stream in under
// random gaps and back-pressure, and every result is compared against an
// independent HSV calculation.
// ----------------------------------------------------------------------------
module tb_top
   import rth_pkg::*;
();

   // Sextant offsets of the hue sum, in units of 1/6 of the final hue.
   localparam logic [10:0] HUE_BASE_YELLOW = 11'd256;
   localparam logic [10:0] HUE_BASE_CYAN = 11'd768;
   localparam logic [10:0] HUE_BASE_MAGENTA = 11'd1280;
   localparam logic [15:0] FULL_SCALE = 16'd255;

   localparam int IDLE_PERCENT = 16;
   localparam int LONG_HOLD = 80;
   localparam int SETTLE_CYCLES = 20;
   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic [PIX_W-1:0] value;
      logic [PIX_W-1:0] saturation;
      logic [PIX_W-1:0] hue;
   } hsv_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // hue [7:0], saturation [15:8], value [23:16]

   logic [23:0] pixel_queue[$];
   hsv_type hsv_expected[$];

   // Control flags, each written by one process only.
   logic req_taken = 1'b0;
   logic steady = 1'b0;
   logic hold_armed = 1'b0;
   logic hold_done = 1'b0;
   int hold_left = 0;

   int error_count = 0;
   int pixels_sent = 0;
   int results_seen = 0;
   int stall_cycles = 0;
   int quiet_cycles = 0;
   hsv_type want;
   hsv_type got;

   rgb_to_hsv_convert uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Expected HSV for one pixel. Red wins ties for the largest component
   // over green, and green over blue; the sextant is then picked by which
   // component equals the smallest.
   function automatic hsv_type predict_hsv(input logic [23:0] pix);
      logic [PIX_W-1:0] red, green, blue, top, bottom, span;
      logic [15:0] sat_wide;
      logic [15:0] term;
      logic [10:0] hue_sum;
      hsv_type res;
      red = pix[7:0];
      green = pix[15:8];
      blue = pix[23:16];
      top = red;
      bottom = red;
      if (green > top) top = green;
      if (blue > top) top = blue;
      if (green < bottom) bottom = green;
      if (blue < bottom) bottom = blue;
      span = top - bottom;
      res.value = top;
      res.saturation = '0;
      res.hue = '0;
      if (top != 0) begin
         sat_wide = (FULL_SCALE * {8'd0, span}) / {8'd0, top};
         res.saturation = sat_wide[7:0];
      end
      // Black and grey pixels keep a hue of zero and never divide by span.
      if (res.saturation != 0 && span != 0) begin
         if (top == red) begin
            if (bottom == green) begin
               term = (FULL_SCALE * {8'd0, top - blue}) / {8'd0, span};
               hue_sum = term[10:0] + HUE_BASE_MAGENTA;
            end else begin
               term = (FULL_SCALE * {8'd0, top - green}) / {8'd0, span};
               hue_sum = HUE_BASE_YELLOW - term[10:0];
            end
         end else if (top == green) begin
            if (bottom == blue) begin
               term = (FULL_SCALE * {8'd0, top - red}) / {8'd0, span};
               hue_sum = term[10:0] + HUE_BASE_YELLOW;
            end else begin
               term = (FULL_SCALE * {8'd0, top - blue}) / {8'd0, span};
               hue_sum = HUE_BASE_CYAN - term[10:0];
            end
         end else if (bottom == red) begin
            term = (FULL_SCALE * {8'd0, top - green}) / {8'd0, span};
            hue_sum = term[10:0] + HUE_BASE_CYAN;
         end else begin
            term = (FULL_SCALE * {8'd0, top - red}) / {8'd0, span};
            hue_sum = HUE_BASE_MAGENTA - term[10:0];
         end
         res.hue = 8'(hue_sum / 11'd6);
      end
      return res;
   endfunction

   // Random pixel, weighted toward near-grey colors, ties and the extremes,
   // since those are where the sextant choice and the dividers get tested.
   function automatic logic [23:0] random_pixel();
      logic [PIX_W-1:0] red, green, blue, base;
      int kind;
      kind = $urandom_range(99);
      red = 8'($urandom);
      green = 8'($urandom);
      blue = 8'($urandom);
      if (kind < 20) begin
         base = 8'($urandom);
         red = base + 8'($urandom_range(3));
         green = base + 8'($urandom_range(3));
         blue = base + 8'($urandom_range(3));
      end else if (kind < 35) begin
         case ($urandom_range(2))
            0: green = red;
            1: blue = green;
            default: blue = red;
         endcase
      end else if (kind < 45) begin
         if ($urandom_range(1) == 1) red = $urandom_range(1) == 1 ? 8'd255 : 8'd0;
         if ($urandom_range(1) == 1) green = $urandom_range(1) == 1 ? 8'd255 : 8'd0;
         if ($urandom_range(1) == 1) blue = $urandom_range(1) == 1 ? 8'd255 : 8'd0;
      end
      return {blue, green, red};
   endfunction

   // Request driver: a new pixel is offered once the previous request was
   // taken, unless a random gap falls on this cycle.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pixel_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
            req_tvalid <= 1'b1;
            req_tdata <= pixel_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver. Once armed, it refuses results for a long stretch so
   // that the pipeline fills and pushes back on the request side.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Monitor: checks each result against the oldest expectation, then
   // records the expectation for a request taken at the same edge. A result
   // can never belong to a request taken at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && !req_tready) stall_cycles <= stall_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            got = rsp_tdata;
            if (hsv_expected.size() == 0) begin
               $display("%0t: result %h arrived with nothing expected", $time, rsp_tdata);
               error_count = error_count + 1;
            end else begin
               want = hsv_expected.pop_front();
               if (got.hue != want.hue) begin
                  $display("%0t: hue expected %0d, actual %0d", $time, want.hue, got.hue);
                  error_count = error_count + 1;
               end
               if (got.saturation != want.saturation) begin
                  $display("%0t: saturation expected %0d, actual %0d",
                           $time, want.saturation, got.saturation);
                  error_count = error_count + 1;
               end
               if (got.value != want.value) begin
                  $display("%0t: value expected %0d, actual %0d", $time, want.value, got.value);
                  error_count = error_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            hsv_expected.push_back(predict_hsv(req_tdata));
            pixels_sent <= pixels_sent + 1;
         end
      end
   end

   // Watchdog: too long without any handshake on either side means a hang.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("rgb_to_hsv_convert regression: fail");
         $finish;
      end
   end

   // Waits until every queued pixel was taken and every result came back.
   task automatic wait_drained();
      while (pixel_queue.size() != 0 || req_tvalid || hsv_expected.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic queue_random(input int count);
      repeat (count) pixel_queue.push_back(random_pixel());
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests, packed as {blue, green, red}.
      pixel_queue.push_back({8'd0, 8'd0, 8'd0});         // black
      pixel_queue.push_back({8'd255, 8'd255, 8'd255});   // white
      pixel_queue.push_back({8'd128, 8'd128, 8'd128});   // mid grey
      pixel_queue.push_back({8'd0, 8'd0, 8'd255});       // red
      pixel_queue.push_back({8'd0, 8'd255, 8'd0});       // green
      pixel_queue.push_back({8'd255, 8'd0, 8'd0});       // blue
      pixel_queue.push_back({8'd0, 8'd255, 8'd255});     // yellow
      pixel_queue.push_back({8'd255, 8'd255, 8'd0});     // cyan
      pixel_queue.push_back({8'd255, 8'd0, 8'd255});     // magenta
      pixel_queue.push_back({8'd100, 8'd10, 8'd200});    // red top, green bottom
      pixel_queue.push_back({8'd10, 8'd100, 8'd200});    // red top, blue bottom
      pixel_queue.push_back({8'd5, 8'd200, 8'd10});      // green top, blue bottom
      pixel_queue.push_back({8'd100, 8'd200, 8'd5});     // green top, red bottom
      pixel_queue.push_back({8'd200, 8'd100, 8'd5});     // blue top, red bottom
      pixel_queue.push_back({8'd200, 8'd5, 8'd100});     // blue top, green bottom
      pixel_queue.push_back({8'd50, 8'd200, 8'd200});    // red and green tie on top
      pixel_queue.push_back({8'd200, 8'd200, 8'd50});    // green and blue tie on top
      pixel_queue.push_back({8'd200, 8'd50, 8'd200});    // red and blue tie on top
      pixel_queue.push_back({8'd0, 8'd0, 8'd1});         // smallest nonzero top
      pixel_queue.push_back({8'd0, 8'd1, 8'd1});         // tiny yellow
      pixel_queue.push_back({8'd254, 8'd254, 8'd255});   // smallest span at full scale
      pixel_queue.push_back({8'd1, 8'd2, 8'd3});         // small span, blue bottom
      pixel_queue.push_back({8'd170, 8'd85, 8'd42});     // odd bit patterns
      wait_drained();

      // Random traffic with gaps on both sides.
      @(posedge clock);
      queue_random(250);
      wait_drained();

      // Back-to-back traffic without any gaps.
      @(posedge clock);
      steady <= 1'b1;
      queue_random(150);
      wait_drained();
      steady <= 1'b0;

      // Long receiver hold while requests keep coming.
      @(posedge clock);
      queue_random(150);
      hold_armed <= 1'b1;
      queue_random(150);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Converted %0d pixels and checked %0d results: primaries, greys, ties,",
               pixels_sent, results_seen);
      $display("all six sextants, %0d cycles of request back-pressure.", stall_cycles);
      if (error_count == 0) begin
         $display("rgb_to_hsv_convert regression: pass");
      end else begin
         $display("rgb_to_hsv_convert regression: fail");
      end
      $finish;
   end

endmodule
